// ===== hdl/llsd_pkg.sv =====
`default_nettype none
package llsd_pkg;

  localparam int DEF_MAX_SERVERS = 16;
  localparam int DEF_LOAD_WIDTH  = 32;

  localparam int SRV_W        = 5;
  localparam int DUR_W        = 16;
  localparam int CFG_W        = 5;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 16;
  localparam int OUT_FIELDS_W = 2 * SRV_W + 1;

  // highest server number the 5-bit server count can reach
  localparam int MAX_ADDRESSABLE = (1 << SRV_W) - 1;

  localparam logic ACT_ASSIGN = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_DONE
  } llsd_state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } llsd_mem_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/llsd_load_mem.sv =====
`default_nettype none
module llsd_load_mem import llsd_pkg::*; #(
  parameter int DEPTH  = DEF_MAX_SERVERS,
  parameter int LOAD_W = DEF_LOAD_WIDTH,
  parameter int AW     = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire llsd_mem_ctl_t       ctl,
  input  wire logic [AW-1:0]       rd_addr,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire logic [LOAD_W-1:0]   wr_data,
  output logic      [LOAD_W-1:0]   rd_data
);

  logic [LOAD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [LOAD_W-1:0] rd_data_r;
  logic              rd_ok_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // entries not written since the last clear read as zero
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      vld_r   <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_ok_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_ok_r ? rd_data_r : '0;

endmodule
`default_nettype wire

// ===== hdl/least_loaded_server_dispatch.sv =====
`default_nettype none
// Least-loaded server dispatch. Each assign transfer (in_tuser = 0) hands its
// job duration to the active server with the smallest accumulated load, lowest
// server number on ties, and adds the duration to that load, saturating at the
// all-ones load value. A clear transfer (in_tuser = 1) zeroes every load at
// once. Each input transfer yields one output transfer carrying the assigned
// server (0 for clear), the server that would take the next job, and the
// saturation flag. cfg_data sets the active server count (0 acts as 1, values
// above MAX_SERVERS act as MAX_SERVERS); write it only while the block is idle.
// Loads live in a single-port-read memory that is scanned one entry per cycle.
// An assign passes through the scan, update and done states before the next
// transfer is accepted, and a clear goes straight to done. A finished result
// waits in the output register while the next transfer is accepted.
module least_loaded_server_dispatch import llsd_pkg::*; #(
  parameter int MAX_SERVERS = DEF_MAX_SERVERS,
  parameter int LOAD_WIDTH  = DEF_LOAD_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] duration
  input  wire logic                   in_tuser,   // [0] action
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // [4:0] assigned_server,
                                                  // [9:5] next_server,
                                                  // [10] saturated
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_W-1:0]       cfg_data    // [4:0] num_servers
);

  localparam int DEPTH = (MAX_SERVERS < MAX_ADDRESSABLE) ? MAX_SERVERS : MAX_ADDRESSABLE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SUM_W = ((LOAD_WIDTH > DUR_W) ? LOAD_WIDTH : DUR_W) + 1;
  localparam logic [LOAD_WIDTH-1:0] LOAD_MAX = '1;

  llsd_state_t state_r, state_nxt;

  logic [CFG_W-1:0]      cfg_num_r;
  logic [CW-1:0]         n_act;
  logic [AW-1:0]         last_idx;

  logic [CW-1:0]         iss_cnt_r;
  logic                  rd_vld_r;
  logic [AW-1:0]         rd_idx_r;
  logic [DUR_W-1:0]      dur_r;
  logic                  clr_r;
  logic [LOAD_WIDTH-1:0] best_val_r;
  logic [AW-1:0]         best_idx_r;
  logic [LOAD_WIDTH-1:0] run_val_r;
  logic [AW-1:0]         run_idx_r;
  logic                  run_vld_r;
  logic [LOAD_WIDTH-1:0] new_val_r;
  logic                  sat_r;
  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  llsd_mem_ctl_t         mem_ctl;
  logic [AW-1:0]         rd_addr;
  logic [LOAD_WIDTH-1:0] rd_data;
  logic [LOAD_WIDTH-1:0] wr_data;

  logic                  in_acc;
  logic                  out_free;
  logic [SUM_W-1:0]      sum;
  logic                  sat_c;
  logic                  k_is_next;
  logic [AW-1:0]         nxt_idx;
  logic [SRV_W-1:0]      asg_srv;
  logic [SRV_W-1:0]      nxt_srv;
  logic                  sat_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_num_r <= CFG_W'(1);
    end else if (cfg_valid) begin
      cfg_num_r <= cfg_data;
    end
  end

  always_comb begin
    priority if (cfg_num_r == '0) begin
      n_act = CW'(1);
    end else if (cfg_num_r > CFG_W'(DEPTH)) begin
      n_act = CW'(DEPTH);
    end else begin
      n_act = CW'(cfg_num_r);
    end
  end

  assign last_idx = AW'(n_act - CW'(1));

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == ACT_CLEAR) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_vld_r && rd_idx_r == last_idx) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    in_tready     = (state_r == ST_IDLE);
    mem_ctl.rd_en = (state_r == ST_SCAN) && (iss_cnt_r < n_act);
    mem_ctl.wr_en = (state_r == ST_UPD);
    mem_ctl.clr   = in_acc && (in_tuser == ACT_CLEAR);
  end

  assign rd_addr = iss_cnt_r[AW-1:0];

  assign sum     = SUM_W'(best_val_r) + SUM_W'(dur_r);
  assign sat_c   = sum > SUM_W'(LOAD_MAX);
  assign wr_data = sat_c ? LOAD_MAX : sum[LOAD_WIDTH-1:0];

  llsd_load_mem #(
    .DEPTH  (DEPTH),
    .LOAD_W (LOAD_WIDTH),
    .AW     (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (best_idx_r),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_cnt_r <= '0;
      rd_vld_r  <= 1'b0;
      run_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= mem_ctl.rd_en;
      if (in_acc) begin
        iss_cnt_r <= '0;
      end else if (mem_ctl.rd_en) begin
        iss_cnt_r <= iss_cnt_r + CW'(1);
      end
      if (state_r == ST_SCAN && rd_vld_r) begin
        if (rd_idx_r == '0) begin
          run_vld_r <= 1'b0;
        end else if (rd_data < best_val_r || !run_vld_r || rd_data < run_val_r) begin
          run_vld_r <= 1'b1;
        end
      end
    end
  end

  // running minimum and runner-up; strict compares keep the lowest index
  always_ff @(posedge clk) begin
    rd_idx_r <= rd_addr;
    if (in_acc) begin
      dur_r <= in_tdata[DUR_W-1:0];
      clr_r <= (in_tuser == ACT_CLEAR);
    end
    if (state_r == ST_SCAN && rd_vld_r) begin
      if (rd_idx_r == '0) begin
        best_val_r <= rd_data;
        best_idx_r <= rd_idx_r;
      end else if (rd_data < best_val_r) begin
        run_val_r  <= best_val_r;
        run_idx_r  <= best_idx_r;
        best_val_r <= rd_data;
        best_idx_r <= rd_idx_r;
      end else if (!run_vld_r || rd_data < run_val_r) begin
        run_val_r <= rd_data;
        run_idx_r <= rd_idx_r;
      end
    end
    if (state_r == ST_UPD) begin
      new_val_r <= wr_data;
      sat_r     <= sat_c;
    end
  end

  always_comb begin
    k_is_next = !run_vld_r || (new_val_r < run_val_r) ||
                ((new_val_r == run_val_r) && (best_idx_r < run_idx_r));
    nxt_idx   = k_is_next ? best_idx_r : run_idx_r;
    asg_srv   = clr_r ? '0 : SRV_W'(best_idx_r) + SRV_W'(1);
    nxt_srv   = clr_r ? SRV_W'(1) : SRV_W'(nxt_idx) + SRV_W'(1);
    sat_out   = clr_r ? 1'b0 : sat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= {(OUT_TDATA_W - OUT_FIELDS_W)'(0), sat_out, nxt_srv, asg_srv};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ===== hdl/llsd_checker.sv =====
`default_nettype none
module llsd_checker import llsd_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transfer accepted before first completed");

  a_next_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2*SRV_W-1:SRV_W] != '0)
    else $error("next server is zero");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[SRV_W-1:0] == '0 |->
      out_tdata[2*SRV_W-1:SRV_W] == SRV_W'(1) && !out_tdata[2*SRV_W])
    else $error("malformed clear result");

endmodule

bind least_loaded_server_dispatch llsd_checker u_llsd_checker (.*);
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import llsd_pkg::*;

  localparam int NUM_SRV        = DEF_MAX_SERVERS;
  localparam int LOAD_W         = DEF_LOAD_WIDTH;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTED    = 40;
  localparam int N_DIRECTED     = 26;
  localparam int RAND_PHASES    = 8;
  localparam int JOBS_PER_PHASE = 100;
  localparam logic [DUR_W-1:0] DUR_MAX = '1;

  typedef struct packed {
    logic             saturated;
    logic [SRV_W-1:0] next_srv;
    logic [SRV_W-1:0] assigned_srv;
  } dispatch_t;

  typedef enum logic {ROW_CFG, ROW_JOB} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic             act;
    logic [DUR_W-1:0] val;
    logic             typed;
    logic             sat;
    logic [SRV_W-1:0] nxt;
    logic [SRV_W-1:0] asg;
  } plan_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = ACT_ASSIGN;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data   = '0;

  logic [LOAD_W-1:0] load_model [NUM_SRV];
  int                active_srv = 1;
  dispatch_t         expected_dispatch [$];
  int                mismatches = 0;
  bit                idle_en = 1'b1;
  int                stall_left = 0;
  int                quiet_cycles = 0;
  plan_row_t         directed_plan [N_DIRECTED];

  always #1 clk = ~clk;

  least_loaded_server_dispatch #(
    .MAX_SERVERS(NUM_SRV),
    .LOAD_WIDTH (LOAD_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  function automatic int least_loaded_idx();
    int best;
    best = 0;
    for (int i = 1; i < active_srv; i++) begin
      if (load_model[i] < load_model[best]) best = i;
    end
    return best;
  endfunction

  function automatic dispatch_t dispatch_job(logic act, logic [DUR_W-1:0] dur);
    dispatch_t         res;
    int                k;
    logic [LOAD_W:0]   sum;
    res = '0;
    if (act == ACT_CLEAR) begin
      for (int i = 0; i < NUM_SRV; i++) load_model[i] = '0;
    end else begin
      k   = least_loaded_idx();
      sum = {1'b0, load_model[k]} + (LOAD_W + 1)'(dur);
      if (sum[LOAD_W]) begin
        load_model[k] = '1;
        res.saturated = 1'b1;
      end else begin
        load_model[k] = sum[LOAD_W-1:0];
      end
      res.assigned_srv = SRV_W'(k + 1);
    end
    res.next_srv = SRV_W'(least_loaded_idx() + 1);
    return res;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 3))
      0: return DUR_W'($urandom_range(0, 15));
      1: return $urandom_range(0, 1) ? DUR_MAX : '0;
      2: return DUR_W'($urandom_range(0, 255));
      default: return DUR_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_count();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CFG_W'(1);
      2: return CFG_W'(NUM_SRV);
      3: return '1;
      4: return CFG_W'($urandom_range(1, 4));
      default: return CFG_W'($urandom_range(0, 31));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_dispatch(input dispatch_t got);
    dispatch_t want;
    if (expected_dispatch.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: %h", got));
    end else begin
      want = expected_dispatch.pop_front();
      if (got.assigned_srv !== want.assigned_srv)
        report_mismatch($sformatf("assigned_server got %0d exp %0d",
                                  got.assigned_srv, want.assigned_srv));
      if (got.next_srv !== want.next_srv)
        report_mismatch($sformatf("next_server got %0d exp %0d",
                                  got.next_srv, want.next_srv));
      if (got.saturated !== want.saturated)
        report_mismatch($sformatf("saturated got %b exp %b",
                                  got.saturated, want.saturated));
    end
  endtask

  // call right after a rising edge
  task automatic send_job(input logic act, input logic [DUR_W-1:0] dur,
                          input logic typed, input dispatch_t typed_res);
    int        gap;
    dispatch_t res;
    gap = idle_en ? gap_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= dur;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = dispatch_job(act, dur);
    expected_dispatch.push_back(typed ? typed_res : res);
  endtask

  task automatic write_servers(input logic [CFG_W-1:0] count);
    in_tvalid <= 1'b0;
    while (expected_dispatch.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (count == 0) active_srv = 1;
    else if (count > NUM_SRV) active_srv = NUM_SRV;
    else active_srv = count;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      check_dispatch(dispatch_t'(out_tdata[OUT_FIELDS_W-1:0]));
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (idle_en && $urandom_range(0, 3) == 0) stall_left <= gap_len();
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    dispatch_t typed_res;
    for (int i = 0; i < NUM_SRV; i++) load_model[i] = '0;
    // kind, action, duration or count, typed, sat, next, assigned
    directed_plan = '{
      '{ROW_JOB, ACT_ASSIGN, 16'h0000, 1'b1, 1'b0, 5'd1, 5'd1},
      '{ROW_JOB, ACT_ASSIGN, 16'hFFFF, 1'b1, 1'b0, 5'd1, 5'd1},
      '{ROW_CFG, ACT_ASSIGN, 16'd0,    1'b0, 1'b0, 5'd0, 5'd0},
      '{ROW_JOB, ACT_ASSIGN, 16'h0001, 1'b1, 1'b0, 5'd1, 5'd1},
      '{ROW_CFG, ACT_ASSIGN, 16'd4,    1'b0, 1'b0, 5'd0, 5'd0},
      '{ROW_JOB, ACT_ASSIGN, 16'h0005, 1'b0, 1'b0, 5'd0, 5'd0},
      '{ROW_JOB, ACT_ASSIGN, 16'h0005, 1'b0, 1'b0, 5'd0, 5'd0},
      '{ROW_JOB, ACT_ASSIGN, 16'h0005, 1'b0, 1'b0, 5'd0, 5'd0},
      '{ROW_JOB, ACT_ASSIGN, 16'h0000, 1'b0, 1'b0, 5'd0, 5'd0},
      '{ROW_JOB, ACT_CLEAR,  16'h0000, 1'b1, 1'b0, 5'd1, 5'd0},
      '{ROW_CFG, ACT_ASSIGN, 16'd31,   1'b0, 1'b0, 5'd0, 5'd0},
      '{ROW_JOB, ACT_ASSIGN, 16'hFFFF, 1'b1, 1'b0, 5'd2, 5'd1},
      '{ROW_JOB, ACT_ASSIGN, 16'hAAAA, 1'b0, 1'b0, 5'd0, 5'd0},
      '{ROW_JOB, ACT_ASSIGN, 16'h5555, 1'b0, 1'b0, 5'd0, 5'd0},
      '{ROW_CFG, ACT_ASSIGN, 16'd16,   1'b0, 1'b0, 5'd0, 5'd0},
      '{ROW_JOB, ACT_ASSIGN, 16'h0001, 1'b0, 1'b0, 5'd0, 5'd0},
      '{ROW_JOB, ACT_CLEAR,  16'hFFFF, 1'b1, 1'b0, 5'd1, 5'd0},
      '{ROW_CFG, ACT_ASSIGN, 16'd17,   1'b0, 1'b0, 5'd0, 5'd0},
      '{ROW_JOB, ACT_ASSIGN, 16'h8000, 1'b0, 1'b0, 5'd0, 5'd0},
      '{ROW_JOB, ACT_ASSIGN, 16'h7FFF, 1'b0, 1'b0, 5'd0, 5'd0},
      '{ROW_CFG, ACT_ASSIGN, 16'd2,    1'b0, 1'b0, 5'd0, 5'd0},
      '{ROW_JOB, ACT_ASSIGN, 16'h0003, 1'b0, 1'b0, 5'd0, 5'd0},
      '{ROW_CFG, ACT_ASSIGN, 16'd1,    1'b0, 1'b0, 5'd0, 5'd0},
      '{ROW_JOB, ACT_ASSIGN, 16'h0002, 1'b0, 1'b0, 5'd0, 5'd0},
      '{ROW_CFG, ACT_ASSIGN, 16'd16,   1'b0, 1'b0, 5'd0, 5'd0},
      '{ROW_JOB, ACT_ASSIGN, 16'h0000, 1'b0, 1'b0, 5'd0, 5'd0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        write_servers(directed_plan[i].val[CFG_W-1:0]);
      end else begin
        typed_res = {directed_plan[i].sat, directed_plan[i].nxt, directed_plan[i].asg};
        send_job(directed_plan[i].act, directed_plan[i].val, directed_plan[i].typed, typed_res);
      end
    end

    // a single server takes every job, then three servers are set for two more jobs
    write_servers(CFG_W'(1));
    send_job(ACT_CLEAR, '0, 1'b0, '0);
    send_job(ACT_ASSIGN, DUR_MAX, 1'b1, {1'b0, 5'd1, 5'd1});
    send_job(ACT_ASSIGN, '0, 1'b1, {1'b0, 5'd1, 5'd1});
    send_job(ACT_ASSIGN, DUR_W'(1), 1'b1, {1'b0, 5'd1, 5'd1});
    write_servers(CFG_W'(3));
    send_job(ACT_ASSIGN, DUR_W'(16'h0100), 1'b0, '0);
    send_job(ACT_ASSIGN, DUR_MAX, 1'b0, '0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      write_servers(pick_count());
      repeat (JOBS_PER_PHASE)
        send_job(($urandom_range(0, 19) == 0) ? ACT_CLEAR : ACT_ASSIGN,
                 pick_duration(), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (expected_dispatch.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (mismatches == 0 && expected_dispatch.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
